@@ src/haversine_distance_assert.svh @@
// ----------------------------------------------------------------------------
// haversine distance assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_ASSERT_SVH
`define HAVERSINE_DISTANCE_ASSERT_SVH

// same-cycle implication
`define HD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("haversine_distance check failed");

// next-cycle implication
`define HD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("haversine_distance check failed");

`endif

@@ src/hd_pkg.sv @@
// ----------------------------------------------------------------------------
// hd_pkg
// types and constants of the haversine distance pipeline
// ----------------------------------------------------------------------------
package hd_pkg;

    localparam logic [31:0] PHASE_K_LO = 32'd3589101257;
    localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [22:0] RADIUS_RESET = 23'd6371000;

    localparam logic [29:0] ATAN_TURNS [0:31] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
    };

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
    } rot_t;

    typedef struct packed {
        logic [62:0] n;
        logic [63:0] res;
        logic [31:0] aux;
    } sqrt_t;

    typedef struct packed {
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic signed [33:0] z;
        logic [31:0]        aux;
    } vec_t;

endpackage

@@ src/haversine_distance.sv @@
// ----------------------------------------------------------------------------
// haversine_distance
// great-circle distance of two points by the haversine formula
// ----------------------------------------------------------------------------
// Takes one point pair per cycle while the skid entry is empty and returns one
// word per pair, in order: four rows of CORDIC_STAGES rotation cells give the
// cosines, two rows of 32 root cells give sqrt(a) and sqrt(1-a), and one row of
// CORDIC_STAGES vectoring cells gives the angle; multiplies sit between them.
// A two-entry output buffer keeps input flowing while a result waits.
// ----------------------------------------------------------------------------
module haversine_distance #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [22:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_latitude, first_longitude, second_latitude, second_longitude
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance_m, haversine_term
    output logic [63:0]  m_tdata
);

    localparam int N = CORDIC_STAGES;
    localparam int LAT = 2 * N + 44;

    logic [22:0] radius_reg;
    logic [LAT-1:0] vld_reg;
    logic en;

    logic signed [30:0] ang_next [4];
    logic signed [30:0] ang_reg [4], ang2_reg [4];
    logic signed [63:0] prod_next [4];
    logic [31:0] hi_reg [4];
    logic [31:0] a32 [4], m6 [4], p [4], pf [4];
    hd_pkg::rot_t rot_c [4][0:N];
    hd_pkg::rot_t rot_init [4];
    logic signed [33:0] xc [4];
    logic signed [31:0] cos_reg [4];
    logic signed [32:0] hlat_reg, hlon_reg, hlat2_reg, hlon2_reg, hlat3_reg;
    logic signed [61:0] ccprod_reg;
    logic signed [62:0] cc_tmp;
    logic signed [31:0] cc_reg;
    logic signed [65:0] prod2_reg;
    logic signed [65:0] p2_tmp;
    logic signed [35:0] a_sum;
    logic [31:0] a_reg;
    hd_pkg::sqrt_t sq_c [2][0:32];
    hd_pkg::vec_t vec_c [0:N];
    logic signed [33:0] zf;
    logic [30:0] zc_reg;
    logic [31:0] a_h_reg, a_p_reg, a_t_reg, a_d_reg;
    logic [62:0] thprod_reg;
    logic [62:0] th_tmp;
    logic [31:0] theta_reg;
    logic [54:0] dprod_reg;
    logic [55:0] dist_tmp;

    logic main_valid_reg, main_valid_next, skid_valid_reg, skid_valid_next;
    logic [63:0] main_data_reg, main_data_next, skid_data_reg, skid_data_next;
    logic in_v;
    logic [63:0] in_d;

    assign cfg_ready = 1'b1;
    assign en = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= hd_pkg::RADIUS_RESET;
        end else if (cfg_valid) begin
            radius_reg <= cfg_data;
        end
    end

    // angle differences and point angles
    always_comb begin
        ang_next[0] = {{2{s_tdata[87]}}, s_tdata[87:59]} - {{2{s_tdata[28]}}, s_tdata[28:0]};
        ang_next[1] = {s_tdata[117], s_tdata[117:88]} - {s_tdata[58], s_tdata[58:29]};
        ang_next[2] = {{2{s_tdata[28]}}, s_tdata[28:0]};
        ang_next[3] = {{2{s_tdata[87]}}, s_tdata[87:59]};
    end

    generate
        for (genvar k = 0; k < 4; k++) begin : g_cos
            always_comb begin
                prod_next[k] = ang_reg[k] * $signed({1'b0, hd_pkg::PHASE_K_LO});
                a32[k] = {ang2_reg[k][30], ang2_reg[k]};
                m6[k] = (a32[k] << 1) + (a32[k] << 2);
                p[k] = hi_reg[k] + m6[k];
                rot_init[k].flip = p[k][31] ^ p[k][30];
                pf[k] = rot_init[k].flip ? p[k] + 32'h80000000 : p[k];
                rot_init[k].x = hd_pkg::INV_GAIN;
                rot_init[k].y = '0;
                rot_init[k].z = {{2{pf[k][31]}}, pf[k]};
                xc[k] = rot_c[k][N].x;
                if (xc[k] > 34'sd1073741824) begin
                    xc[k] = 34'sd1073741824;
                end
                if (xc[k] < -34'sd1073741824) begin
                    xc[k] = -34'sd1073741824;
                end
                if (rot_c[k][N].flip) begin
                    xc[k] = -xc[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    ang_reg[k]  <= ang_next[k];
                    ang2_reg[k] <= ang_reg[k];
                    hi_reg[k]   <= prod_next[k][63:32];
                    rot_c[k][0] <= rot_init[k];
                    cos_reg[k]  <= xc[k][31:0];
                end
            end

            for (genvar i = 0; i < N; i++) begin : g_cell
                hd_rot_cell #(.IDX(i)) u_cell (
                    .aclk  (aclk),
                    .en    (en),
                    .d_in  (rot_c[k][i]),
                    .d_out (rot_c[k][i+1])
                );
            end
        end
    endgenerate

    // haversine term
    always_comb begin
        cc_tmp = 63'(ccprod_reg) + 63'sd536870912;
        p2_tmp = prod2_reg + 66'sd536870912;
        a_sum = 36'(hlat3_reg) + 36'(p2_tmp >>> 30);
        if (a_sum < 0) begin
            a_sum = '0;
        end
        if (a_sum > 36'sd2147483648) begin
            a_sum = 36'sd2147483648;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hlat_reg   <= 33'sd1073741824 - 33'(cos_reg[0]);
            hlon_reg   <= 33'sd1073741824 - 33'(cos_reg[1]);
            ccprod_reg <= cos_reg[2] * cos_reg[3];
            hlat2_reg  <= hlat_reg;
            hlon2_reg  <= hlon_reg;
            cc_reg     <= 32'(cc_tmp >>> 30);
            hlat3_reg  <= hlat2_reg;
            prod2_reg  <= 66'(cc_reg) * 66'(hlon2_reg);
            a_reg      <= a_sum[31:0];
        end
    end

    // square roots of a and 1-a
    always_comb begin
        sq_c[0][0].n   = {a_reg, 31'b0};
        sq_c[0][0].res = '0;
        sq_c[0][0].aux = a_reg;
        sq_c[1][0].n   = {32'h80000000 - a_reg, 31'b0};
        sq_c[1][0].res = '0;
        sq_c[1][0].aux = a_reg;
    end

    generate
        for (genvar k = 0; k < 2; k++) begin : g_sqrt
            for (genvar i = 0; i < 32; i++) begin : g_cell
                hd_sqrt_cell #(.IDX(i)) u_cell (
                    .aclk  (aclk),
                    .en    (en),
                    .d_in  (sq_c[k][i]),
                    .d_out (sq_c[k][i+1])
                );
            end
        end
    endgenerate

    // angle of the (sqrt(1-a), sqrt(a)) vector
    always_comb begin
        vec_c[0].x   = {3'b0, sq_c[1][32].res[31:0]};
        vec_c[0].y   = {3'b0, sq_c[0][32].res[31:0]};
        vec_c[0].z   = '0;
        vec_c[0].aux = sq_c[0][32].aux;
        zf = vec_c[N].z;
        if (zf < 0) begin
            zf = '0;
        end
        if (zf > 34'sd1073741824) begin
            zf = 34'sd1073741824;
        end
    end

    generate
        for (genvar i = 0; i < N; i++) begin : g_vec
            hd_vec_cell #(.IDX(i)) u_cell (
                .aclk  (aclk),
                .en    (en),
                .d_in  (vec_c[i]),
                .d_out (vec_c[i+1])
            );
        end
    endgenerate

    // angle to meters
    always_comb begin
        th_tmp = thprod_reg + 63'd536870912;
        dist_tmp = {1'b0, dprod_reg} + 56'd536870912;
        in_v = vld_reg[LAT-1] && en;
        in_d = {7'b0, a_d_reg, dist_tmp[54:30]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zc_reg     <= zf[30:0];
            a_h_reg    <= vec_c[N].aux;
            thprod_reg <= zc_reg * hd_pkg::PI_Q30;
            a_p_reg    <= a_h_reg;
            theta_reg  <= th_tmp[61:30];
            a_t_reg    <= a_p_reg;
            dprod_reg  <= radius_reg * theta_reg;
            a_d_reg    <= a_t_reg;
        end
    end

    // output register with skid entry
    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (m_tready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_v;
                main_data_next  = in_d;
            end
        end else if (in_v) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;

endmodule

@@ src/hd_rot_cell.sv @@
// ----------------------------------------------------------------------------
// hd_rot_cell
// one rotation step of the cosine cell row
// ----------------------------------------------------------------------------
module hd_rot_cell #(
    parameter int IDX = 0
) (
    input  logic         aclk,
    input  logic         en,
    input  hd_pkg::rot_t d_in,
    output hd_pkg::rot_t d_out
);

    hd_pkg::rot_t cell_reg, cell_next;
    logic signed [33:0] xi, yi, zi, dx, dy, atn;

    always_comb begin
        xi = d_in.x;
        yi = d_in.y;
        zi = d_in.z;
        dx = yi >>> IDX;
        dy = xi >>> IDX;
        atn = $signed({4'b0, hd_pkg::ATAN_TURNS[IDX]});
        cell_next.flip = d_in.flip;
        if (zi >= 0) begin
            cell_next.x = xi - dx;
            cell_next.y = yi + dy;
            cell_next.z = zi - atn;
        end else begin
            cell_next.x = xi + dx;
            cell_next.y = yi - dy;
            cell_next.z = zi + atn;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign d_out = cell_reg;

endmodule

@@ src/hd_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// hd_sqrt_cell
// one bit step of the floor square root cell row
// ----------------------------------------------------------------------------
module hd_sqrt_cell #(
    parameter int IDX = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  hd_pkg::sqrt_t d_in,
    output hd_pkg::sqrt_t d_out
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

    hd_pkg::sqrt_t cell_reg, cell_next;
    logic [63:0] trial;

    always_comb begin
        trial = d_in.res + BIT;
        cell_next.aux = d_in.aux;
        if ({1'b0, d_in.n} >= trial) begin
            cell_next.n   = 63'({1'b0, d_in.n} - trial);
            cell_next.res = (d_in.res >> 1) + BIT;
        end else begin
            cell_next.n   = d_in.n;
            cell_next.res = d_in.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign d_out = cell_reg;

endmodule

@@ src/hd_vec_cell.sv @@
// ----------------------------------------------------------------------------
// hd_vec_cell
// one vectoring step of the angle cell row
// ----------------------------------------------------------------------------
module hd_vec_cell #(
    parameter int IDX = 0
) (
    input  logic         aclk,
    input  logic         en,
    input  hd_pkg::vec_t d_in,
    output hd_pkg::vec_t d_out
);

    hd_pkg::vec_t cell_reg, cell_next;
    logic signed [34:0] xi, yi, dx, dy;
    logic signed [33:0] zi, atn;

    always_comb begin
        xi = d_in.x;
        yi = d_in.y;
        zi = d_in.z;
        dx = yi >>> IDX;
        dy = xi >>> IDX;
        atn = $signed({4'b0, hd_pkg::ATAN_TURNS[IDX]});
        cell_next.aux = d_in.aux;
        if (yi > 0) begin
            cell_next.x = xi + dx;
            cell_next.y = yi - dy;
            cell_next.z = zi + atn;
        end else begin
            cell_next.x = xi - dx;
            cell_next.y = yi + dy;
            cell_next.z = zi - atn;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign d_out = cell_reg;

endmodule

@@ src/hd_checker.sv @@
// ----------------------------------------------------------------------------
// hd_checker
// port checks of the haversine distance block
// ----------------------------------------------------------------------------
`include "haversine_distance_assert.svh"

module hd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata
);

    `HD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `HD_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
    `HD_ASSERT_NOW(a_term_clamp, m_tvalid, m_tdata[56:25] <= 32'h80000000)
    `HD_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[63:57] == 7'd0)

endmodule

bind haversine_distance hd_checker u_hd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ sim/haversine_distance_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_checker
// watches the config, input and output channels of haversine_distance, works
// out the expected distance and haversine term of every accepted point pair
// and compares them, in order, with the words that leave the block
// ----------------------------------------------------------------------------
module haversine_distance_checker #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [22:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    output int           mismatches,
    output int           pending
);

    typedef struct packed {
        logic [24:0] distance_m;
        logic [31:0] haversine_term;
    } leg_t;

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint ONE_Q31 = 64'sd2147483648;

    logic [22:0] radius;
    leg_t        expected_legs[$];

    function automatic longint cos_fix(longint ang);
        logic [63:0] prod;
        logic [31:0] p;
        logic [31:0] t;
        logic        flip;
        longint      x, y, z, dx, dy;
        prod = ang * 64'd29358905033;
        p = prod[63:32];
        t = p + 32'h4000_0000;
        flip = t[31];
        if (flip) p = p + 32'h8000_0000;
        z = longint'($signed(p));
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(hd_pkg::ATAN_TURNS[i]);
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(hd_pkg::ATAN_TURNS[i]);
            end
        end
        if (x > ONE_Q30) x = ONE_Q30;
        if (x < -ONE_Q30) x = -ONE_Q30;
        return flip ? -x : x;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic leg_t great_circle(logic [119:0] d, logic [22:0] r);
        longint      lat1, lon1, lat2, lon2, hlat, hlon, cc, a, x, y, z, dx, dy;
        logic [63:0] theta, dist_m;
        leg_t        leg;
        lat1 = longint'($signed(d[28:0]));
        lon1 = longint'($signed(d[58:29]));
        lat2 = longint'($signed(d[87:59]));
        lon2 = longint'($signed(d[117:88]));
        hlat = ONE_Q30 - cos_fix(lat2 - lat1);
        hlon = ONE_Q30 - cos_fix(lon2 - lon1);
        cc = (cos_fix(lat1) * cos_fix(lat2) + (64'sd1 <<< 29)) >>> 30;
        a = hlat + ((cc * hlon + (64'sd1 <<< 29)) >>> 30);
        if (a < 0) a = 0;
        if (a > ONE_Q31) a = ONE_Q31;
        y = longint'(floor_root(64'(a) << 31));
        x = longint'(floor_root(64'(ONE_Q31 - a) << 31));
        z = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + longint'(hd_pkg::ATAN_TURNS[i]);
            end else begin
                x = x - dx; y = y + dy; z = z - longint'(hd_pkg::ATAN_TURNS[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > ONE_Q30) z = ONE_Q30;
        theta = (64'(z) * 64'd3373259426 + (64'd1 << 29)) >> 30;
        dist_m = (64'(r) * theta + (64'd1 << 29)) >> 30;
        leg.distance_m = dist_m[24:0];
        leg.haversine_term = a[31:0];
        return leg;
    endfunction

    assign pending = expected_legs.size();

    always @(posedge aclk) begin
        leg_t want, got;
        if (!aresetn) begin
            radius <= hd_pkg::RADIUS_RESET;
            mismatches <= 0;
            expected_legs.delete();
        end else begin
            if (cfg_valid && cfg_ready) radius <= cfg_data;
            if (s_tvalid && s_tready) expected_legs.push_back(great_circle(s_tdata, radius));
            if (m_tvalid && m_tready) begin
                got.distance_m = m_tdata[24:0];
                got.haversine_term = m_tdata[56:25];
                if (expected_legs.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected word %h", $realtime, m_tdata);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_legs.pop_front();
                    if (want != got || m_tdata[63:57] != 0) begin
                        if (mismatches < 10)
                            $display("%0t: distance exp %0d got %0d, term exp %h got %h",
                                $realtime, want.distance_m, got.distance_m,
                                want.haversine_term, got.haversine_term);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

@@ sim/haversine_distance_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_tb
// drives point pairs through haversine_distance under several radius settings
// and idle patterns, with a long output hold-off; the checker judges results
// ----------------------------------------------------------------------------
module haversine_distance_tb;

    localparam int LAT_MAX = 157079633;
    localparam int LON_MAX = 314159265;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [22:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // first_latitude, first_longitude, second_latitude, second_longitude
    logic [119:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // distance_m, haversine_term
    logic [63:0]  m_tdata;

    int mismatches, pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    haversine_distance dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    haversine_distance_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .mismatches(mismatches), .pending(pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_pair(logic [28:0] lat1, logic [29:0] lon1,
                             logic [28:0] lat2, logic [29:0] lon2);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 8) gap++;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {2'b00, lon2, lat2, lon1, lat1};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_radius(logic [22:0] r);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (150) @(negedge aclk);
        cfg_data = r;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [28:0] rand_lat();
        if ($urandom_range(9) == 0) return 29'($urandom);
        return 29'(int'($urandom_range(2 * LAT_MAX)) - LAT_MAX);
    endfunction

    function automatic logic [29:0] rand_lon();
        if ($urandom_range(9) == 0) return 30'($urandom);
        return 30'(int'($urandom_range(2 * LON_MAX)) - LON_MAX);
    endfunction

    task automatic random_pairs(int n);
        logic [28:0] lat1, lat2;
        logic [29:0] lon1, lon2;
        for (int k = 0; k < n; k++) begin
            lat1 = rand_lat();
            lon1 = rand_lon();
            case ($urandom_range(3))
                0: begin
                    // nearby points
                    lat2 = lat1 + 29'(int'($urandom_range(20000)) - 10000);
                    lon2 = lon1 + 30'(int'($urandom_range(20000)) - 10000);
                end
                1: begin
                    // near antipodal
                    lat2 = -lat1 + 29'(int'($urandom_range(2000)) - 1000);
                    lon2 = lon1 + 30'(LON_MAX) + 30'($urandom_range(2000));
                end
                default: begin
                    lat2 = rand_lat();
                    lon2 = rand_lon();
                end
            endcase
            send_pair(lat1, lon1, lat2, lon2);
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // default radius first, then directed pairs
        send_pair(0, 0, 0, 0);
        send_pair(29'(LAT_MAX), 0, 29'(-LAT_MAX), 0);
        send_pair(0, 30'(-LON_MAX), 0, 30'(LON_MAX));
        send_pair(0, 0, 0, 30'(LON_MAX));
        send_pair(29'(LAT_MAX), 30'(LON_MAX), 29'(LAT_MAX), 30'(-LON_MAX));
        send_pair(29'h0FFF_FFFF, 30'h1FFF_FFFF, 29'h1000_0000, 30'h2000_0000);
        send_pair(29'h1FFF_FFFF, 30'h3FFF_FFFF, 29'h1FFF_FFFF, 30'h3FFF_FFFF);
        send_pair(29'h1000_0000, 30'h2000_0000, 29'h0FFF_FFFF, 30'h1FFF_FFFF);
        send_pair(1, 0, 0, 1);
        send_pair(29'd78539816, 30'd100, 29'(-78539816), 30'(-LON_MAX + 100));
        send_pair(29'd50000000, 30'd50000000, 29'd50000001, 30'd50000000);
        send_pair(29'(-LAT_MAX), 0, 29'(-LAT_MAX), 30'd157079633);
        send_pair(0, 0, 0, 30'd314159266);
        send_pair(29'h1555_5555, 30'h2AAA_AAAA, 29'h0AAA_AAAA, 30'h1555_5555);

        write_radius(23'd6371000);
        random_pairs(150);

        write_radius(23'd6300000);
        send_idle_pct = 66;
        random_pairs(150);

        write_radius(23'd6400000);
        send_idle_pct = 0;
        recv_stall_pct = 66;
        random_pairs(150);

        write_radius(23'h7F_FFFF);
        send_idle_pct = 20;
        recv_stall_pct = 20;
        random_pairs(150);

        write_radius(23'd0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_pairs(80);

        write_radius(23'($urandom_range(6400000, 6300000)));
        // long hold-off so the block backs up into its input
        hold_cycles = 400;
        random_pairs(250);
        send_idle_pct = 66;
        recv_stall_pct = 66;
        random_pairs(120);

        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
